>>> hw/rtl/hyperbolic_sinh_cosh_halving_unit_assert.svh
// Assertion macros shared by the sinh/cosh unit RTL.
`ifndef HYPERBOLIC_SINH_COSH_HALVING_UNIT_ASSERT_SVH
`define HYPERBOLIC_SINH_COSH_HALVING_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define HSCU_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define HSCU_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hscu_pkg.sv
// Package: widths, constants, job type and state encodings for the sinh/cosh unit.
`timescale 1ns / 1ps
package hscu_pkg;

    localparam int ARG_W     = 28;
    localparam int SINH_W    = 40;
    localparam int COSH_W    = 39;
    localparam int HALV_W    = 5;
    localparam int THR_W     = 21;
    localparam int N_W       = 6;
    localparam int LIM_W     = ARG_W + 1;

    localparam int IFRAC     = 50;
    localparam int T_W       = 62;
    localparam int H_W       = T_W / 2;
    localparam int P_W       = 2 * T_W;

    localparam int DIV_W     = 64;
    localparam int DIV_CHUNK = 8;
    localparam int DIV_STEPS = DIV_W / DIV_CHUNK;

    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(17);
    localparam logic [T_W-1:0]    CAP_M1    = {T_W{1'b1}};
    localparam logic [T_W-1:0]    ONE       = {{(T_W-IFRAC-1){1'b0}}, 1'b1, {IFRAC{1'b0}}};
    localparam logic [COSH_W-1:0] OUT_MAX   = {COSH_W{1'b1}};

    typedef struct packed {
        logic           neg;
        logic [N_W-1:0] n;
        logic [T_W-1:0] t;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQ,
        B_CUBE,
        B_DIV,
        B_SEED,
        B_STEP,
        B_SC,
        B_SS,
        B_FIN
    } t_bstate;

endpackage

>>> hw/rtl/hyperbolic_sinh_cosh_halving_unit.sv
// Top level of the sinh/cosh unit: threshold register, front end, job queue, back end.
`timescale 1ns / 1ps
// Computes sinh and cosh of a signed Q4.24 argument together, in Q15.24, and
// reports n, the number of argument halvings (and doubling steps) used.
// Input channel: i_valid / o_stall with i_argument; a request is taken at an
//   edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_sinh_value, o_cosh_value and
//   o_halvings_used; a result is taken where o_valid is high and i_stall low.
// Config: i_cfg_we writes i_cfg_wdata into the threshold; write only when idle.
// Front end: scans n one compare per cycle, then hands the reduced
//   argument to a two-entry queue. It takes the next request while
//   the back end is still busy with earlier ones.
// Back end: one 31x31 multiplier, four partial products per 62-bit product.
//   Seeding takes two products and a divide by three; each doubling step
//   takes two products.
// Reset (synchronous, active low) empties the queue, drops any pending result
//   and sets the threshold to 17. While i_stall is high the result holds in the
//   output register; the back end waits in its final state, the queue fills
//   and then o_stall stays high.
module hyperbolic_sinh_cosh_halving_unit import hscu_pkg::*; #(
    parameter int FRAC_BITS    = 24,
    parameter int MAX_HALVINGS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [THR_W-1:0]         i_cfg_wdata,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [ARG_W-1:0]  i_argument,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [SINH_W-1:0] o_sinh_value,
    output logic [COSH_W-1:0]        o_cosh_value,
    output logic [HALV_W-1:0]        o_halvings_used
);

    logic [THR_W-1:0] r_thr;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_q_valid;
    t_job w_push_job;
    t_job w_q_job;

    // threshold: magnitude in Q4.24 below which the series seed applies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    hscu_front #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_HALVINGS (MAX_HALVINGS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_argument (i_argument),
        .i_thr      (r_thr),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // decouple the scan from the multiply loop
    hscu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    hscu_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_job         (w_q_job),
        .o_q_pop         (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_sinh_value    (o_sinh_value),
        .o_cosh_value    (o_cosh_value),
        .o_halvings_used (o_halvings_used)
    );

endmodule

>>> hw/rtl/hscu_front.sv
// Front end: takes requests, finds the halving count and forms the reduced argument.
`timescale 1ns / 1ps
module hscu_front import hscu_pkg::*; #(
    parameter int FRAC_BITS    = 24,
    parameter int MAX_HALVINGS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [ARG_W-1:0] i_argument,
    input  logic [THR_W-1:0] i_thr,
    input  logic             i_full,
    output logic             o_push,
    output t_job             o_job
);

    localparam int E_MAX = IFRAC - FRAC_BITS;
    localparam int WW    = ARG_W + E_MAX + 1;
    localparam int XW    = (WW > T_W) ? WW : T_W + 1;

    t_fstate          r_state;
    t_fstate          n_state;
    logic [ARG_W-1:0] r_m;
    logic             r_neg;
    logic [N_W-1:0]   r_n;
    logic [LIM_W-1:0] r_lim;

    logic             w_scan_go;
    logic [XW-1:0]    w_base;
    logic [XW-1:0]    w_rnd;
    logic [XW-1:0]    w_sum;
    logic [XW-1:0]    w_sh;

    // threshold << n, one bit a step; stop past the magnitude or at MAX_HALVINGS
    assign w_scan_go = (r_n < N_W'(MAX_HALVINGS)) && ({1'b0, r_m} >= r_lim);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_valid) n_state = F_SCAN;
            F_SCAN: if (!w_scan_go) n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != F_IDLE);
        o_push  = (r_state == F_PUSH) && !i_full;
    end

    // t = m * 2^(E_MAX - n), rounded half up when the shift goes right
    always_comb begin
        w_base    = XW'({r_m, {E_MAX{1'b0}}});
        w_rnd     = (r_n == '0) ? '0 : (XW'(1) << (r_n - N_W'(1)));
        w_sum     = w_base + w_rnd;
        w_sh      = w_sum >> r_n;
        o_job.neg = r_neg;
        o_job.n   = r_n;
        o_job.t   = (|w_sh[XW-1:T_W]) ? CAP_M1 : w_sh[T_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_neg <= i_argument[ARG_W-1];
            r_m   <= i_argument[ARG_W-1] ? (~i_argument + ARG_W'(1)) : i_argument;
            r_n   <= '0;
            r_lim <= LIM_W'(i_thr);
        end else if (r_state == F_SCAN && w_scan_go) begin
            r_n   <= r_n + N_W'(1);
            r_lim <= {r_lim[LIM_W-2:0], 1'b0};
        end
    end

endmodule

>>> hw/rtl/hscu_queue.sv
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps
`include "hyperbolic_sinh_cosh_halving_unit_assert.svh"
module hscu_queue import hscu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int DEPTH = 2;

    t_job       r_ent [DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == 2'(DEPTH));
    assign o_job   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'(1);
                2'b01:   r_cnt <= r_cnt - 2'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_job;
    end

    `HSCU_IMPLIES(a_q_no_overflow, i_push, !o_full, "queue push while full")
    `HSCU_IMPLIES(a_q_no_underflow, i_pop, o_valid, "queue pop while empty")

endmodule

>>> hw/rtl/hscu_fmul.sv
// Multi-cycle Q.50 multiplier: four 31x31 partial products, rounding and saturation.
`timescale 1ns / 1ps
`include "hyperbolic_sinh_cosh_halving_unit_assert.svh"
module hscu_fmul import hscu_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [T_W-1:0] i_a,
    input  logic [T_W-1:0] i_b,
    output logic           o_done,
    output logic [T_W-1:0] o_prod
);

    localparam logic [P_W-1:0] RND      = P_W'(1) << (IFRAC - 1);
    localparam logic [2:0]     LAST_CNT = 3'd4;

    logic [T_W-1:0]   r_a;
    logic [T_W-1:0]   r_b;
    logic             r_busy;
    logic [2:0]       r_cnt;
    logic [2*H_W-1:0] r_pp;
    logic [1:0]       r_pp_idx;
    logic             r_pp_vld;
    logic [P_W-1:0]   r_acc;
    logic             r_done;

    logic [H_W-1:0]   w_x;
    logic [H_W-1:0]   w_y;
    logic [2*H_W-1:0] w_mul;
    logic [P_W-1:0]   w_addend;

    // issue order: lo*lo, lo*hi, hi*lo, hi*hi
    assign w_x   = r_cnt[1] ? r_a[T_W-1:H_W] : r_a[H_W-1:0];
    assign w_y   = r_cnt[0] ? r_b[T_W-1:H_W] : r_b[H_W-1:0];
    assign w_mul = (2*H_W)'(w_x) * (2*H_W)'(w_y);

    always_comb begin
        unique case (r_pp_idx)
            2'd0:       w_addend = P_W'(r_pp);
            2'd1, 2'd2: w_addend = P_W'(r_pp) << H_W;
            default:    w_addend = P_W'(r_pp) << (2 * H_W);
        endcase
    end

    assign o_done = r_done;
    assign o_prod = (|r_acc[P_W-1:IFRAC+T_W]) ? CAP_M1 : r_acc[IFRAC+T_W-1:IFRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_pp_vld <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_pp_vld <= 1'b0;
            end else if (r_busy) begin
                if (r_cnt < LAST_CNT) begin
                    r_cnt    <= r_cnt + 3'd1;
                    r_pp_vld <= 1'b1;
                end else begin
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                    r_pp_vld <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= RND;
        end else begin
            if (r_busy && r_cnt < LAST_CNT) begin
                r_pp     <= w_mul;
                r_pp_idx <= r_cnt[1:0];
            end
            if (r_pp_vld) r_acc <= r_acc + w_addend;
        end
    end

    `HSCU_IMPLIES(a_fmul_start_idle, i_start, !r_busy, "multiplier started while busy")

endmodule

>>> hw/rtl/hscu_back.sv
// Back end: series seed, doubling steps on the shared multiplier, output register.
`timescale 1ns / 1ps
`include "hyperbolic_sinh_cosh_halving_unit_assert.svh"
module hscu_back import hscu_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  t_job                     i_q_job,
    output logic                     o_q_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [SINH_W-1:0] o_sinh_value,
    output logic [COSH_W-1:0]        o_cosh_value,
    output logic [HALV_W-1:0]        o_halvings_used
);

    localparam int             D       = IFRAC - FRAC_BITS;
    localparam logic [T_W:0]   OUT_RND = (T_W + 1)'(1) << (D - 1);
    localparam logic [2:0]     DIV_END = 3'(DIV_STEPS - 1);

    t_bstate            r_state;
    t_bstate            n_state;
    logic [T_W-1:0]     r_t;
    logic [T_W-1:0]     r_t2;
    logic [T_W-1:0]     r_s;
    logic [T_W-1:0]     r_c;
    logic [T_W-1:0]     r_sc;
    logic [N_W-1:0]     r_n;
    logic [N_W-1:0]     r_cnt;
    logic               r_neg;
    logic [DIV_W-1:0]   r_dy;
    logic [DIV_W-1:0]   r_dq;
    logic [1:0]         r_drem;
    logic [2:0]         r_dcnt;
    logic               r_ov;
    logic [SINH_W-1:0]  r_osinh;
    logic [COSH_W-1:0]  r_ocosh;
    logic [HALV_W-1:0]  r_ohalv;

    logic               w_mul_start;
    logic [T_W-1:0]     w_mul_a;
    logic [T_W-1:0]     w_mul_b;
    logic               w_mul_done;
    logic [T_W-1:0]     w_mul_prod;
    logic               w_out_free;

    logic [T_W:0]       w_cube_sum;
    logic [1:0]         w_rem;
    logic [2:0]         w_v;
    logic [DIV_CHUNK-1:0] w_qb;
    logic [T_W:0]       w_seed_s;
    logic [T_W:0]       w_half;
    logic [T_W:0]       w_seed_c;
    logic [T_W:0]       w_dbl_s;
    logic [T_W+1:0]     w_dbl_c;
    logic [T_W:0]       w_s_sum;
    logic [T_W:0]       w_c_sum;
    logic [T_W:0]       w_s_q;
    logic [T_W:0]       w_c_q;
    logic [COSH_W-1:0]  w_s_mag;
    logic [COSH_W-1:0]  w_c_mag;
    logic [SINH_W-1:0]  w_s_pos;

    hscu_fmul u_fmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    assign w_out_free = !r_ov || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_q_valid) n_state = B_SQ;
            B_SQ:   if (w_mul_done) n_state = B_CUBE;
            B_CUBE: if (w_mul_done) n_state = B_DIV;
            B_DIV:  if (r_dcnt == DIV_END) n_state = B_SEED;
            B_SEED: n_state = B_STEP;
            B_STEP: n_state = (r_cnt == '0) ? B_FIN : B_SC;
            B_SC:   if (w_mul_done) n_state = B_SS;
            B_SS:   if (w_mul_done) n_state = B_STEP;
            B_FIN:  if (w_out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        w_mul_start = 1'b0;
        w_mul_a     = r_s;
        w_mul_b     = r_c;
        unique case (r_state)
            B_IDLE: begin
                o_q_pop     = i_q_valid;
                w_mul_start = i_q_valid;
                w_mul_a     = i_q_job.t;
                w_mul_b     = i_q_job.t;
            end
            B_SQ: begin
                w_mul_start = w_mul_done;
                w_mul_a     = w_mul_prod;
                w_mul_b     = r_t;
            end
            B_STEP: begin
                w_mul_start = (r_cnt != '0);
            end
            B_SC: begin
                w_mul_start = w_mul_done;
                w_mul_b     = r_s;
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    // divide by three, one byte a cycle, MSB first
    always_comb begin
        w_rem = r_drem;
        w_v   = '0;
        w_qb  = '0;
        for (int i = 0; i < DIV_CHUNK; i++) begin
            w_v = {w_rem, r_dy[DIV_W-1-i]};
            if (w_v >= 3'd3) begin
                w_qb[DIV_CHUNK-1-i] = 1'b1;
                w_rem               = 2'(w_v - 3'd3);
            end else begin
                w_qb[DIV_CHUNK-1-i] = 1'b0;
                w_rem               = w_v[1:0];
            end
        end
    end

    always_comb begin
        w_cube_sum = {1'b0, w_mul_prod} + (T_W + 1)'(3);
        w_seed_s   = {1'b0, r_t} + {1'b0, r_dq[T_W-1:0]};
        w_half     = ({1'b0, r_t2} + (T_W + 1)'(1)) >> 1;
        w_seed_c   = {1'b0, ONE} + w_half;
        w_dbl_s    = {r_sc, 1'b0};
        w_dbl_c    = {2'b00, ONE} + {1'b0, w_mul_prod, 1'b0};
    end

    // round to the output format, clamp, then apply the sign to sinh
    always_comb begin
        w_s_sum = {1'b0, r_s} + OUT_RND;
        w_c_sum = {1'b0, r_c} + OUT_RND;
        w_s_q   = w_s_sum >> D;
        w_c_q   = w_c_sum >> D;
        w_s_mag = (w_s_q > (T_W + 1)'(OUT_MAX)) ? OUT_MAX : w_s_q[COSH_W-1:0];
        w_c_mag = (w_c_q > (T_W + 1)'(OUT_MAX)) ? OUT_MAX : w_c_q[COSH_W-1:0];
        w_s_pos = {1'b0, w_s_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_FIN && w_out_free) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    r_t   <= i_q_job.t;
                    r_n   <= i_q_job.n;
                    r_cnt <= i_q_job.n;
                    r_neg <= i_q_job.neg;
                end
            end
            B_SQ: begin
                if (w_mul_done) r_t2 <= w_mul_prod;
            end
            B_CUBE: begin
                if (w_mul_done) begin
                    r_dy   <= DIV_W'(w_cube_sum[T_W:1]);
                    r_dq   <= '0;
                    r_drem <= '0;
                    r_dcnt <= '0;
                end
            end
            B_DIV: begin
                r_dy   <= r_dy << DIV_CHUNK;
                r_dq   <= {r_dq[DIV_W-DIV_CHUNK-1:0], w_qb};
                r_drem <= w_rem;
                r_dcnt <= r_dcnt + 3'd1;
            end
            B_SEED: begin
                r_s <= w_seed_s[T_W] ? CAP_M1 : w_seed_s[T_W-1:0];
                r_c <= w_seed_c[T_W] ? CAP_M1 : w_seed_c[T_W-1:0];
            end
            B_STEP: begin
                if (r_cnt != '0) r_cnt <= r_cnt - N_W'(1);
            end
            B_SC: begin
                if (w_mul_done) r_sc <= w_mul_prod;
            end
            B_SS: begin
                if (w_mul_done) begin
                    r_s <= w_dbl_s[T_W] ? CAP_M1 : w_dbl_s[T_W-1:0];
                    r_c <= (|w_dbl_c[T_W+1:T_W]) ? CAP_M1 : w_dbl_c[T_W-1:0];
                end
            end
            B_FIN: begin
                if (w_out_free) begin
                    r_osinh <= r_neg ? (SINH_W'(0) - w_s_pos) : w_s_pos;
                    r_ocosh <= w_c_mag;
                    r_ohalv <= (r_n > N_W'({HALV_W{1'b1}})) ? {HALV_W{1'b1}}
                                                            : r_n[HALV_W-1:0];
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_valid         = r_ov;
    assign o_sinh_value    = r_osinh;
    assign o_cosh_value    = r_ocosh;
    assign o_halvings_used = r_ohalv;

    `HSCU_IMPLIES(a_back_loop_bound, r_state == B_SC, r_cnt < r_n, "doubling count overran")
    `HSCU_IMPLIES(a_back_cosh_floor, r_state == B_STEP, r_c >= ONE, "cosh fell below one")

endmodule
